/* rtl/iaf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaf_pkg
// Shared types and constants of the IMU angle frame parser.
// ----------------------------------------------------------------------------
package iaf_pkg;

   // Frame layout: sync, type, six angle bytes, three ignored bytes.
   localparam int unsigned FrameLen   = 11;
   localparam int unsigned AngleFirst = 2;
   localparam int unsigned AngleCount = 6;

   // Reset values of the configuration registers.
   localparam logic [7:0] SyncByteReset = 8'h55;
   localparam logic [7:0] TypeByteReset = 8'h53;

   // Register indexes on the configuration port.
   localparam logic RegSyncByte = 1'b0;
   localparam logic RegTypeByte = 1'b1;

   // Scaling and wrap points in Q13 degrees.
   localparam logic [5:0]  RawToQ13  = 6'd45;
   localparam logic [23:0] Deg270Q13 = 24'd2211840;
   localparam logic [23:0] Deg180Q13 = 24'd1474560;
   localparam logic [23:0] Deg360Q13 = 24'd2949120;

   // Byte positions inside a frame.
   localparam logic [3:0] PosSync    = 4'd0;
   localparam logic [3:0] PosType    = 4'd1;
   localparam logic [3:0] PosLast    = 4'(FrameLen - 1);
   localparam logic [3:0] PosAngleLo = 4'(AngleFirst);
   localparam logic [3:0] PosAngleHi = 4'(AngleFirst + AngleCount - 1);

   // Configuration seen by the front end.
   typedef struct packed {
      logic [7:0] sync_byte;
      logic [7:0] type_byte;
   } cfg_type;

   // Raw little-endian angles of one complete frame.
   typedef struct packed {
      logic [15:0] pitch_raw;
      logic [15:0] roll_raw;
      logic [15:0] yaw_raw;
   } raw_frame_type;

   // One scaled result.
   typedef struct packed {
      logic signed [22:0] pitch_angle;
      logic signed [22:0] roll_angle;
      logic signed [21:0] yaw_angle;
   } angle_set_type;

endpackage

/* rtl/iaf_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaf_fifo
// Small register-based FIFO used between the parser stages and at the output.
// ----------------------------------------------------------------------------
module iaf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_write;
   logic             do_read;

   // Status and transfer qualification.
   assign full     = (count_ff == CntW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_write = wr_en && !full;
   assign do_read  = rd_en && !empty;
   assign rd_data  = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_write && !do_read) begin
         count_in = count_ff + 1'b1;
      end else if (do_read && !do_write) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* rtl/iaf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaf_front
// Byte-level frame tracker: hunts for sync, checks the type byte and
// collects the six angle bytes of each frame.
// ----------------------------------------------------------------------------
module iaf_front (
   input  logic                   clock,
   input  logic                   reset,
   input  iaf_pkg::cfg_type       cfg,
   input  logic                   byte_accept,
   input  logic [7:0]             rx_byte,
   output logic                   last_byte,
   output logic                   frame_push,
   output iaf_pkg::raw_frame_type frame
);

   import iaf_pkg::*;

   logic [3:0] byte_position_ff, byte_position_in;
   logic [7:0] angle_bytes_ff [AngleCount];
   logic       angle_write;
   logic [2:0] angle_index;

   // The next byte closes a frame; the queue must have room for it.
   assign last_byte  = (byte_position_ff == PosLast);
   assign frame_push = byte_accept && last_byte;

   assign angle_write = byte_accept && (byte_position_ff >= PosAngleLo) &&
                        (byte_position_ff <= PosAngleHi);
   assign angle_index = byte_position_ff[2:0] - PosAngleLo[2:0];

   // Frame bytes 2..7 hold pitch, roll and yaw, low byte first.
   assign frame.pitch_raw = {angle_bytes_ff[1], angle_bytes_ff[0]};
   assign frame.roll_raw  = {angle_bytes_ff[3], angle_bytes_ff[2]};
   assign frame.yaw_raw   = {angle_bytes_ff[5], angle_bytes_ff[4]};

   // Position tracking: wait for sync, check type, then count to the end.
   always_comb begin
      byte_position_in = byte_position_ff;
      if (byte_accept) begin
         case (byte_position_ff)
            PosSync: begin
               byte_position_in = (rx_byte == cfg.sync_byte) ? PosType : PosSync;
            end
            PosType: begin
               byte_position_in = (rx_byte == cfg.type_byte) ? PosAngleLo : PosSync;
            end
            PosLast: begin
               byte_position_in = PosSync;
            end
            default: begin
               byte_position_in = byte_position_ff + 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= PosSync;
      end else begin
         byte_position_ff <= byte_position_in;
      end
   end

   // Angle byte capture.
   always_ff @(posedge clock) begin
      if (angle_write) begin
         angle_bytes_ff[angle_index] <= rx_byte;
      end
   end

endmodule

/* rtl/iaf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaf_back
// Angle scaling: converts raw frames to Q13 degrees and applies the wraps.
// ----------------------------------------------------------------------------
module iaf_back (
   input  logic                   frame_empty,
   input  iaf_pkg::raw_frame_type frame,
   output logic                   frame_pop,
   input  logic                   result_full,
   output logic                   result_push,
   output iaf_pkg::angle_set_type result
);

   import iaf_pkg::*;

   logic [21:0]        pitch_scaled;
   logic [21:0]        roll_scaled;
   logic [21:0]        yaw_scaled;
   logic signed [23:0] pitch_wrapped;
   logic signed [23:0] pitch_negated;
   logic signed [23:0] roll_wrapped;
   logic signed [23:0] yaw_wrapped;

   // Move a frame whenever the result buffer has room.
   assign frame_pop   = !frame_empty && !result_full;
   assign result_push = frame_pop;

   // raw * 180 / 32768 degrees is exactly raw * 45 in Q13.
   assign pitch_scaled = 22'(frame.pitch_raw) * 22'(RawToQ13);
   assign roll_scaled  = 22'(frame.roll_raw) * 22'(RawToQ13);
   assign yaw_scaled   = 22'(frame.yaw_raw) * 22'(RawToQ13);

   // Pitch and roll wrap at 270 degrees, yaw at 180 degrees.
   always_comb begin
      pitch_wrapped = signed'({2'b00, pitch_scaled});
      if ({2'b00, pitch_scaled} >= Deg270Q13) begin
         pitch_wrapped = signed'({2'b00, pitch_scaled} - Deg360Q13);
      end
      roll_wrapped = signed'({2'b00, roll_scaled});
      if ({2'b00, roll_scaled} >= Deg270Q13) begin
         roll_wrapped = signed'({2'b00, roll_scaled} - Deg360Q13);
      end
      yaw_wrapped = signed'({2'b00, yaw_scaled});
      if ({2'b00, yaw_scaled} >= Deg180Q13) begin
         yaw_wrapped = signed'({2'b00, yaw_scaled} - Deg360Q13);
      end
   end

   // Pitch is reported with the opposite sign.
   assign pitch_negated = -pitch_wrapped;

   assign result.pitch_angle = pitch_negated[22:0];
   assign result.roll_angle  = roll_wrapped[22:0];
   assign result.yaw_angle   = yaw_wrapped[21:0];

endmodule

/* rtl/imu_angle_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_angle_frame_parser
// Both the frame queue and the result buffer are registered on the way out.
// Throughput: one byte per cycle unless full; one result per 11-byte frame.
// full rises only on the final byte of a frame, while the frame queue is full.
// Reset (synchronous, active high) clears the frame position, the queues and
// restores the sync and type registers to 0x55 and 0x53.
// ----------------------------------------------------------------------------
module imu_angle_frame_parser #(
   parameter int QUEUE_DEPTH  = 2,
   parameter int RESULT_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   // Byte input
   input  logic               push,
   output logic               full,
   input  logic [7:0]         req_rx_byte,
   // Result output
   output logic               empty,
   input  logic               pop,
   output logic signed [22:0] rsp_pitch_angle,
   output logic signed [22:0] rsp_roll_angle,
   output logic signed [21:0] rsp_yaw_angle,
   // Configuration
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   import iaf_pkg::*;

   logic [7:0]    sync_byte_ff;
   logic [7:0]    type_byte_ff;
   cfg_type       cfg;
   logic          csr_write;
   logic          byte_accept;
   logic          last_byte;
   logic          frame_push;
   raw_frame_type frame_in;
   raw_frame_type frame_out;
   logic          queue_full;
   logic          queue_empty;
   logic          frame_pop;
   logic          result_push;
   logic          result_full;
   angle_set_type result_in;
   angle_set_type result_out;

   // Configuration registers.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_byte_ff <= SyncByteReset;
         type_byte_ff <= TypeByteReset;
      end else if (csr_write) begin
         if (paddr[2] == RegSyncByte) begin
            sync_byte_ff <= pwdata[7:0];
         end else begin
            type_byte_ff <= pwdata[7:0];
         end
      end
   end

   assign prdata = (paddr[2] == RegSyncByte) ? {24'd0, sync_byte_ff}
                                             : {24'd0, type_byte_ff};

   assign cfg.sync_byte = sync_byte_ff;
   assign cfg.type_byte = type_byte_ff;

   // Input transfer stalls only when a frame cannot be queued.
   assign full        = last_byte && queue_full;
   assign byte_accept = push && !full;

   iaf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .byte_accept (byte_accept),
      .rx_byte     (req_rx_byte),
      .last_byte   (last_byte),
      .frame_push  (frame_push),
      .frame       (frame_in)
   );

   // Frame queue between front and back.
   iaf_fifo #(
      .WIDTH ($bits(raw_frame_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_frame_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (frame_push),
      .wr_data (frame_in),
      .full    (queue_full),
      .rd_en   (frame_pop),
      .rd_data (frame_out),
      .empty   (queue_empty)
   );

   iaf_back u_back (
      .frame_empty (queue_empty),
      .frame       (frame_out),
      .frame_pop   (frame_pop),
      .result_full (result_full),
      .result_push (result_push),
      .result      (result_in)
   );

   // Result buffer drives the output ports.
   iaf_fifo #(
      .WIDTH ($bits(angle_set_type)),
      .DEPTH (RESULT_DEPTH)
   ) u_result_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (result_push),
      .wr_data (result_in),
      .full    (result_full),
      .rd_en   (pop),
      .rd_data (result_out),
      .empty   (empty)
   );

   assign rsp_pitch_angle = result_out.pitch_angle;
   assign rsp_roll_angle  = result_out.roll_angle;
   assign rsp_yaw_angle   = result_out.yaw_angle;

endmodule

/* rtl/iaf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaf_checker
// Port-level checks of the IMU angle frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module iaf_checker (
   input logic               clock,
   input logic               reset,
   input logic               empty,
   input logic               pop,
   input logic               pready,
   input logic signed [22:0] rsp_pitch_angle,
   input logic signed [22:0] rsp_roll_angle,
   input logic signed [21:0] rsp_yaw_angle
);

   // Reset leaves no result waiting.
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result pending after reset");

   // The configuration port never inserts wait states.
   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready dropped");

   // A waiting result holds until its transfer.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_pitch_angle) &&
                            $stable(rsp_roll_angle) && $stable(rsp_yaw_angle)))
      else $error("result changed while stalled");

   // Wrapped roll stays within -90 and 270 degrees.
   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_roll_angle >= -23'sd737280 && rsp_roll_angle <= 23'sd2211795))
      else $error("roll out of range");

   // Wrapped and negated pitch stays within -270 and 90 degrees.
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_pitch_angle >= -23'sd2211795 && rsp_pitch_angle <= 23'sd737280))
      else $error("pitch out of range");

endmodule

bind imu_angle_frame_parser iaf_checker u_iaf_checker (.*);

/* tb/angle_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_frame_checker
// Watches the byte, result and register ports of the IMU angle frame parser.
// It keeps its own frame tracker, queues the angles each complete frame
// should produce, and compares every result transfer with the oldest one.
// ----------------------------------------------------------------------------
module angle_frame_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic               full,
   input  logic [7:0]         rx_byte,
   input  logic               empty,
   input  logic               pop,
   input  logic signed [22:0] pitch_angle,
   input  logic signed [22:0] roll_angle,
   input  logic signed [21:0] yaw_angle,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   input  logic               pready,
   output int                 error_count,
   output int                 pending_count
);

   import iaf_pkg::*;

   // Byte addresses of the two registers.
   localparam logic [2:0] AddrSyncByte = {RegSyncByte, 2'b00};
   localparam logic [2:0] AddrTypeByte = {RegTypeByte, 2'b00};

   logic [7:0]    sync_value;
   logic [7:0]    type_value;
   logic [3:0]    frame_pos;
   logic [7:0]    angle_buf [AngleCount];
   angle_set_type expected_angles [$];
   int            mismatch_total = 0;

   assign error_count = mismatch_total;

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string msg);
      $display("%0t angle check: %s", $time, msg);
      mismatch_total++;
   endtask

   // Scale the six collected bytes to Q13 degrees and apply the wraps.
   function automatic angle_set_type scale_frame_angles();
      angle_set_type result;
      int            pitch;
      int            roll;
      int            yaw;
      pitch = int'({angle_buf[1], angle_buf[0]}) * int'(RawToQ13);
      roll  = int'({angle_buf[3], angle_buf[2]}) * int'(RawToQ13);
      yaw   = int'({angle_buf[5], angle_buf[4]}) * int'(RawToQ13);
      if (pitch >= int'(Deg270Q13)) begin
         pitch = pitch - int'(Deg360Q13);
      end
      pitch = -pitch;
      if (roll >= int'(Deg270Q13)) begin
         roll = roll - int'(Deg360Q13);
      end
      if (yaw >= int'(Deg180Q13)) begin
         yaw = yaw - int'(Deg360Q13);
      end
      result.pitch_angle = pitch[22:0];
      result.roll_angle  = roll[22:0];
      result.yaw_angle   = yaw[21:0];
      return result;
   endfunction

   // Move the frame tracker by one accepted byte.
   task automatic advance_frame(input logic [7:0] rx);
      case (frame_pos)
         PosSync: begin
            if (rx == sync_value) begin
               frame_pos = PosType;
            end
         end
         PosType: begin
            // A wrong type byte drops the frame; it is not rechecked as sync.
            frame_pos = (rx == type_value) ? PosAngleLo : PosSync;
         end
         default: begin
            if (frame_pos >= PosAngleLo && frame_pos <= PosAngleHi) begin
               angle_buf[3'(frame_pos - PosAngleLo)] = rx;
            end
            if (frame_pos == PosLast) begin
               expected_angles.push_back(scale_frame_angles());
               frame_pos = PosSync;
            end else begin
               frame_pos = frame_pos + 4'd1;
            end
         end
      endcase
   endtask

   // Sample all three ports at each rising edge.
   always @(posedge clock) begin : monitor
      angle_set_type want;
      if (reset) begin
         sync_value = SyncByteReset;
         type_value = TypeByteReset;
         frame_pos  = PosSync;
         expected_angles.delete();
      end else begin
         // Result transfer: compare with the oldest expectation.
         if (pop && !empty) begin
            if (expected_angles.size() == 0) begin
               report_mismatch($sformatf("unexpected result pitch %0d roll %0d yaw %0d",
                                         pitch_angle, roll_angle, yaw_angle));
            end else begin
               want = expected_angles.pop_front();
               if (pitch_angle !== want.pitch_angle) begin
                  report_mismatch($sformatf("pitch got %0d expected %0d",
                                            pitch_angle, want.pitch_angle));
               end
               if (roll_angle !== want.roll_angle) begin
                  report_mismatch($sformatf("roll got %0d expected %0d",
                                            roll_angle, want.roll_angle));
               end
               if (yaw_angle !== want.yaw_angle) begin
                  report_mismatch($sformatf("yaw got %0d expected %0d",
                                            yaw_angle, want.yaw_angle));
               end
            end
         end
         // Register write transfer.
         if (psel && penable && pwrite && pready) begin
            case (paddr)
               AddrSyncByte: sync_value = pwdata[7:0];
               AddrTypeByte: type_value = pwdata[7:0];
               default: ;
            endcase
         end
         // Byte transfer.
         if (push && !full) begin
            advance_frame(rx_byte);
         end
      end
      pending_count <= expected_angles.size();
   end

endmodule

/* tb/tb_imu_angle_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_angle_frame_parser
// Drives byte streams, register writes and result pops into the IMU angle
// frame parser: a short directed section with wrap points and framing errors,
// then random frames, broken frames and noise under several sync and type
// settings. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_imu_angle_frame_parser;
   import iaf_pkg::*;

   localparam logic [2:0] AddrSyncByte = {RegSyncByte, 2'b00};
   localparam logic [2:0] AddrTypeByte = {RegTypeByte, 2'b00};
   localparam int HoldCycles   = 300;
   localparam int SettleCycles = 8;
   localparam int CycleLimit   = 200000;
   localparam int PhaseBytes   = 140;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               full;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               empty;
   logic               pop = 1'b0;
   logic signed [22:0] rsp_pitch_angle;
   logic signed [22:0] rsp_roll_angle;
   logic signed [21:0] rsp_yaw_angle;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = 3'd0;
   logic [31:0]        pwdata = 32'd0;
   logic [31:0]        prdata;
   logic               pready;

   int         error_count;
   int         pending_count;
   int         cycle_count = 0;
   int         stall_requests = 0;
   int         stall_served = 0;
   logic       sender_gaps = 1'b1;
   logic       receiver_gaps = 1'b1;
   logic [7:0] cur_sync = SyncByteReset;
   logic [7:0] cur_type = TypeByteReset;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   imu_angle_frame_parser uut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_rx_byte     (req_rx_byte),
      .empty           (empty),
      .pop             (pop),
      .rsp_pitch_angle (rsp_pitch_angle),
      .rsp_roll_angle  (rsp_roll_angle),
      .rsp_yaw_angle   (rsp_yaw_angle),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   angle_frame_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .rx_byte       (req_rx_byte),
      .empty         (empty),
      .pop           (pop),
      .pitch_angle   (rsp_pitch_angle),
      .roll_angle    (rsp_roll_angle),
      .yaw_angle     (rsp_yaw_angle),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .pready        (pready),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("tb_imu_angle_frame_parser: errors");
         $finish;
      end
   end

   // Result side: random pop gaps, plus one long hold-off on request.
   initial begin : receiver
      int gap;
      wait (!reset);
      forever begin
         if (stall_requests != stall_served) begin
            stall_served++;
            pop <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
            pop <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clock);
         end else begin
            pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offer one byte, with an occasional gap first, until it transfers.
   task automatic send_byte(input logic [7:0] rx);
      int gap;
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         push <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
      push        <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (full);
   endtask

   // One complete frame under the current sync and type settings.
   task automatic send_frame(input logic [15:0] pitch_raw, input logic [15:0] roll_raw,
                             input logic [15:0] yaw_raw, input logic [23:0] tail);
      send_byte(cur_sync);
      send_byte(cur_type);
      send_byte(pitch_raw[7:0]);
      send_byte(pitch_raw[15:8]);
      send_byte(roll_raw[7:0]);
      send_byte(roll_raw[15:8]);
      send_byte(yaw_raw[7:0]);
      send_byte(yaw_raw[15:8]);
      send_byte(tail[7:0]);
      send_byte(tail[15:8]);
      send_byte(tail[23:16]);
   endtask

   // Raw angle, biased toward the ends of the range and the wrap points.
   function automatic logic [15:0] pick_raw();
      logic [15:0] corner_raw [6] = '{16'd0, 16'hFFFF, 16'd32767, 16'd32768,
                                      16'd49151, 16'd49152};
      if ($urandom_range(0, 3) == 0) begin
         return corner_raw[$urandom_range(0, 5)];
      end
      return 16'($urandom_range(0, 65535));
   endfunction

   // Stop sending and wait until every expected result has transferred.
   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready.
   task automatic csr_write(input logic [2:0] addr, input logic [7:0] value);
      logic [23:0] upper;
      upper   = 24'($urandom());
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= {upper, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Change both framing bytes while the parser is idle.
   task automatic set_framing(input logic [7:0] sync_new, input logic [7:0] type_new);
      drain();
      csr_write(AddrSyncByte, sync_new);
      csr_write(AddrTypeByte, type_new);
      cur_sync = sync_new;
      cur_type = type_new;
   endtask

   // Mostly well-formed frames with random content; the rest are broken
   // frames and noise bytes.
   task automatic run_random(input int budget);
      int          sent;
      int          noise;
      logic [23:0] tail;
      logic [7:0]  bad_type;
      sent = 0;
      while (sent < budget) begin
         case ($urandom_range(0, 19))
            15, 16: begin
               bad_type = 8'($urandom_range(0, 255));
               if (bad_type == cur_type) begin
                  bad_type = bad_type ^ 8'h01;
               end
               send_byte(cur_sync);
               send_byte(bad_type);
               sent += 2;
            end
            17, 18, 19: begin
               noise = $urandom_range(1, 4);
               repeat (noise) send_byte(8'($urandom_range(0, 255)));
               sent += noise;
            end
            default: begin
               tail = ($urandom_range(0, 3) == 0) ? {3{cur_sync}} : 24'($urandom());
               send_frame(pick_raw(), pick_raw(), pick_raw(), tail);
               sent += 11;
            end
         endcase
      end
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a stray byte, a sync followed by a wrong type byte equal
      // to sync, then frames across the wrap points with sync inside data.
      send_byte(TypeByteReset);
      send_byte(SyncByteReset);
      send_byte(SyncByteReset);
      send_frame(16'd49151, 16'd49152, 16'hFFFF, {3{SyncByteReset}});
      send_frame(16'd0, 16'hFFFF, 16'd32768, 24'h00FF00);

      // Long receiver hold-off while the sender keeps offering frames.
      set_framing(8'h00, 8'hFF);
      sender_gaps = 1'b0;
      stall_requests <= stall_requests + 1;
      repeat (14) send_frame(pick_raw(), pick_raw(), pick_raw(), 24'($urandom()));
      sender_gaps = 1'b1;
      run_random(PhaseBytes);

      set_framing(8'hFF, 8'h00);
      run_random(PhaseBytes);

      set_framing(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      run_random(PhaseBytes);

      set_framing(8'hAA, 8'hAA);
      run_random(PhaseBytes);

      // Last part: back to reset framing, no gaps on either side.
      set_framing(SyncByteReset, TypeByteReset);
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      run_random(PhaseBytes);

      drain();
      if (error_count == 0 && pending_count == 0) begin
         $display("tb_imu_angle_frame_parser: clean");
      end else begin
         $display("tb_imu_angle_frame_parser: errors");
      end
      $finish;
   end

endmodule
